// ----- src/rnc_pkg.sv -----
// Package for the fixed-radius neighbour counter: sizes, payload structs,
// cell control struct and controller state type.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rnc_pkg;

  // Number of point cells in the chain (2 to 64).
  localparam int unsigned MAX_POINTS = 64;
  // Index of one cell.
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  // Fill level, able to hold MAX_POINTS itself.
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned SQ_W     = 2 * COORD_W;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 6'd63;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'd25600;

  // Input item.
  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [COUNT_W-1:0] neighbor_count;
    logic               last_count;
  } out_t;

  // A stored point.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  // The copy of a point that travels round the ring of cells.
  typedef struct packed {
    logic   valid;
    point_t point;
  } travel_t;

  // Controls common to every cell.
  typedef struct packed {
    logic setup;   // load travelling copies, clear counts
    logic rotate;  // compare and pass the travelling copy on
    logic shift;   // move counts one cell towards the output
    logic clear;   // empty the set
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_ROTATE,
    ST_DRAIN,
    ST_OUT
  } state_e;

endpackage

// ----- src/radius_neighbor_counter.sv -----
// Fixed-radius neighbour counter: a ring of point cells and its sequencer.
// Depends on rnc_pkg, rnc_cell and rnc_ctrl.
// Points are loaded while the input is ready. After the final point, the
// ring passes a setup step, the rotation and a drain step, then gives one
// count per cycle while the receiver is ready. Reset empties the set and
// sets the radius to 160 pixels (squared radius 25600).
module radius_neighbor_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rnc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rnc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rnc_pkg::RADIUS_W-1:0]  cfg_wdata_i
);

  logic [rnc_pkg::RADIUS_W-1:0]  radius_q;
  rnc_pkg::cell_ctrl_t           cell_ctrl;
  logic                          wr_en;
  logic [rnc_pkg::IDX_W-1:0]     wr_idx;
  logic                          out_last;
  rnc_pkg::point_t               wr_point;
  rnc_pkg::travel_t              travel [rnc_pkg::MAX_POINTS];
  logic [rnc_pkg::COUNT_W-1:0]   count  [rnc_pkg::MAX_POINTS];

  // Squared radius register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rnc_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Sequencer.
  rnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_point),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_last_o  (out_last),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .cell_ctrl_o (cell_ctrl)
  );

  assign wr_point.x = in_data_i.point_x;
  assign wr_point.y = in_data_i.point_y;

  // Ring of cells; counts drain towards cell zero.
  for (genvar k = 0; k < rnc_pkg::MAX_POINTS; k++) begin : g_cell
    localparam int unsigned PREV = (k == 0) ? rnc_pkg::MAX_POINTS - 1 : k - 1;
    logic [rnc_pkg::COUNT_W-1:0] next_count;

    if (k == rnc_pkg::MAX_POINTS - 1) begin : g_tail
      assign next_count = '0;
    end else begin : g_body
      assign next_count = count[k+1];
    end

    rnc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .wr_en_i    (wr_en && (wr_idx == rnc_pkg::IDX_W'(k))),
      .wr_point_i (wr_point),
      .radius_i   (radius_q),
      .travel_i   (travel[PREV]),
      .travel_o   (travel[k]),
      .count_i    (next_count),
      .count_o    (count[k])
    );
  end

  // Result item.
  always_comb begin
    out_data_o.neighbor_count = count[0];
    out_data_o.last_count     = out_last;
  end

endmodule

// ----- src/rnc_cell.sv -----
// One cell of the neighbour counter chain: holds one point, compares it with
// the travelling copy each rotation step and accumulates its own count.
// Depends on rnc_pkg.
module rnc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rnc_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          wr_en_i,
  input  rnc_pkg::point_t               wr_point_i,
  input  logic [rnc_pkg::RADIUS_W-1:0]  radius_i,
  input  rnc_pkg::travel_t              travel_i,
  output rnc_pkg::travel_t              travel_o,
  input  logic [rnc_pkg::COUNT_W-1:0]   count_i,
  output logic [rnc_pkg::COUNT_W-1:0]   count_o
);

  logic                          own_v_q;
  rnc_pkg::point_t               own_q;
  rnc_pkg::travel_t              travel_q;
  logic [rnc_pkg::COORD_W-1:0]   dx;
  logic [rnc_pkg::COORD_W-1:0]   dy;
  logic [rnc_pkg::SQ_W-1:0]      sqx_q;
  logic [rnc_pkg::SQ_W-1:0]      sqy_q;
  logic                          hit_q;
  logic [rnc_pkg::SQ_W:0]        dist_sq;
  logic                          near;
  logic [rnc_pkg::COUNT_W-1:0]   count_q;

  // Own point and its valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_v_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      own_v_q <= 1'b0;
    end else if (wr_en_i) begin
      own_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      own_q <= wr_point_i;
    end
  end

  // Travelling copy: seeded from the own point, then passed round the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q <= '0;
    end else if (ctrl_i.setup) begin
      travel_q <= {own_v_q, own_q};
    end else if (ctrl_i.rotate) begin
      travel_q <= travel_i;
    end
  end

  assign travel_o = travel_q;

  // First stage: absolute differences, squared and registered.
  always_comb begin
    dx = (own_q.x >= travel_q.point.x) ? (own_q.x - travel_q.point.x)
                                       : (travel_q.point.x - own_q.x);
    dy = (own_q.y >= travel_q.point.y) ? (own_q.y - travel_q.point.y)
                                       : (travel_q.point.y - own_q.y);
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= dx * dx;
    sqy_q <= dy * dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= ctrl_i.rotate && own_v_q && travel_q.valid;
    end
  end

  // Second stage: exact squared distance against the radius.
  always_comb begin
    dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
    near = hit_q && (dist_sq != '0) &&
           (dist_sq < {{(rnc_pkg::SQ_W + 1 - rnc_pkg::RADIUS_W){1'b0}}, radius_i});
  end

  // Count: cleared at setup, incremented on a near point, shifted at output.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      count_q <= '0;
    end else if (ctrl_i.shift) begin
      count_q <= count_i;
    end else if (near && (count_q != rnc_pkg::COUNT_MAX)) begin
      count_q <= count_q + 1'b1;
    end
  end

  assign count_o = count_q;

endmodule

// ----- src/rnc_ctrl.sv -----
// Sequencer of the neighbour counter: loading, rotation of the cell ring and
// delivery of the counts.
// Depends on rnc_pkg.
module rnc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_last_o,
  output logic                        wr_en_o,
  output logic [rnc_pkg::IDX_W-1:0]   wr_idx_o,
  output rnc_pkg::cell_ctrl_t         cell_ctrl_o
);

  rnc_pkg::state_e               state_q, state_d;
  logic [rnc_pkg::CNT_W-1:0]     loaded_q, loaded_d;
  logic [rnc_pkg::IDX_W-1:0]     rot_q, rot_d;
  logic [rnc_pkg::CNT_W-1:0]     oidx_q, oidx_d;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          has_room;
  logic                          rot_end;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign has_room = loaded_q < rnc_pkg::CNT_W'(rnc_pkg::MAX_POINTS);
  assign rot_end  = rot_q == rnc_pkg::IDX_W'(rnc_pkg::MAX_POINTS - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rnc_pkg::ST_LOAD: begin
        if (in_xfer && in_last_i) begin
          state_d = rnc_pkg::ST_SETUP;
        end
      end
      rnc_pkg::ST_SETUP:  state_d = rnc_pkg::ST_ROTATE;
      rnc_pkg::ST_ROTATE: begin
        if (rot_end) begin
          state_d = rnc_pkg::ST_DRAIN;
        end
      end
      rnc_pkg::ST_DRAIN:  state_d = rnc_pkg::ST_OUT;
      rnc_pkg::ST_OUT: begin
        if (out_xfer && out_last_o) begin
          state_d = rnc_pkg::ST_LOAD;
        end
      end
      default: state_d = rnc_pkg::ST_LOAD;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_ready_o         = state_q == rnc_pkg::ST_LOAD;
    out_valid_o        = state_q == rnc_pkg::ST_OUT;
    out_last_o         = (oidx_q + 1'b1) == loaded_q;
    wr_en_o            = in_xfer && has_room;
    wr_idx_o           = loaded_q[rnc_pkg::IDX_W-1:0];
    cell_ctrl_o.setup  = state_q == rnc_pkg::ST_SETUP;
    cell_ctrl_o.rotate = state_q == rnc_pkg::ST_ROTATE;
    cell_ctrl_o.shift  = out_xfer;
    cell_ctrl_o.clear  = out_xfer && out_last_o;
  end

  // Fill level, rotation step and output index.
  always_comb begin
    loaded_d = loaded_q;
    rot_d    = rot_q;
    oidx_d   = oidx_q;
    if (wr_en_o) begin
      loaded_d = loaded_q + 1'b1;
    end
    if (state_q == rnc_pkg::ST_SETUP) begin
      rot_d  = '0;
      oidx_d = '0;
    end else if (state_q == rnc_pkg::ST_ROTATE) begin
      rot_d = rot_q + 1'b1;
    end
    if (out_xfer) begin
      oidx_d = oidx_q + 1'b1;
      if (out_last_o) begin
        loaded_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rnc_pkg::ST_LOAD;
      loaded_q <= '0;
      rot_q    <= '0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      rot_q    <= rot_d;
      oidx_q   <= oidx_d;
    end
  end

  // Checks on the sequencing.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open at once");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= rnc_pkg::CNT_W'(rnc_pkg::MAX_POINTS))
    else $error("fill level beyond the chain length");

  a_empty_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_o) |=> (loaded_q == '0 && in_ready_o))
    else $error("set not emptied after the final count");

  a_rot_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rnc_pkg::ST_SETUP) |=> (state_q == rnc_pkg::ST_ROTATE && rot_q == '0))
    else $error("rotation did not start at step zero");

  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (loaded_q != '0 && oidx_q < loaded_q))
    else $error("count delivered from an empty set");

endmodule

// ----- verif/radius_neighbor_counter_tb.sv -----
// Self-checking testbench for radius_neighbor_counter: sends point sets, predicts every
// neighbour count and compares each count transfer against the prediction.
// Depends on rnc_pkg and the radius_neighbor_counter RTL; needs nothing else.
module radius_neighbor_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Radius settings with a fixed meaning.
  localparam logic [rnc_pkg::RADIUS_W-1:0] RADIUS_NONE    = '0;
  localparam logic [rnc_pkg::RADIUS_W-1:0] RADIUS_ONE     = 32'd1;
  localparam logic [rnc_pkg::RADIUS_W-1:0] RADIUS_WIDEST  = '1;
  // Cycles after the final result before the block is surely idle again.
  localparam int unsigned SETTLE_CYCLES  = rnc_pkg::MAX_POINTS + 8;
  // Long receiver hold-off, and the watchdog limit for cycles without any transfer.
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS   = 115;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  rnc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  rnc_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [rnc_pkg::RADIUS_W-1:0] cfg_wdata = '0;

  // Predictor state: the open point set, the current radius and the counts still owed.
  rnc_pkg::point_t              set_points[$];
  logic [rnc_pkg::RADIUS_W-1:0] radius_now = rnc_pkg::RADIUS_RESET;
  rnc_pkg::out_t                expected_counts[$];

  int unsigned errors = 0;
  int unsigned points_sent = 0;
  int unsigned sets_done = 0;
  int unsigned counts_checked = 0;
  int unsigned radius_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          hold_req = 1'b0;
  bit          quiet = 1'b0;

  radius_neighbor_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock generation.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Number of other points in the set at nonzero squared distance below the radius.
  function automatic logic [rnc_pkg::COUNT_W-1:0] count_neighbours(int idx);
    int unsigned     hits;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned d2;
    hits = 0;
    foreach (set_points[j]) begin
      dx = (set_points[idx].x >= set_points[j].x) ? set_points[idx].x - set_points[j].x
                                                  : set_points[j].x - set_points[idx].x;
      dy = (set_points[idx].y >= set_points[j].y) ? set_points[idx].y - set_points[j].y
                                                  : set_points[j].y - set_points[idx].y;
      d2 = dx * dx + dy * dy;
      if (d2 != 0 && d2 < {32'd0, radius_now} && hits < rnc_pkg::COUNT_MAX) hits++;
    end
    return hits[rnc_pkg::COUNT_W-1:0];
  endfunction

  // Stores an accepted point; the final point of a set yields one count per stored point.
  function automatic void record_point(rnc_pkg::in_t p);
    rnc_pkg::point_t pt;
    rnc_pkg::out_t   res;
    int              n;
    if (set_points.size() < rnc_pkg::MAX_POINTS) begin
      pt.x = p.point_x;
      pt.y = p.point_y;
      set_points.push_back(pt);
    end
    if (!p.last_point) return;
    n = set_points.size();
    for (int i = 0; i < n; i++) begin
      res.neighbor_count = count_neighbours(i);
      res.last_count     = (i == n - 1);
      expected_counts.push_back(res);
    end
    set_points.delete();
    sets_done++;
  endfunction

  // Offers one point and waits for its transfer; valid stays high afterwards.
  task automatic send_point(logic [rnc_pkg::COORD_W-1:0] x, logic [rnc_pkg::COORD_W-1:0] y,
                            logic last);
    rnc_pkg::in_t p;
    int           gap;
    p.point_x    = x;
    p.point_y    = y;
    p.last_point = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk_i); while (!in_ready);
    record_point(p);
    points_sent++;
  endtask

  // Lowers valid and waits until every count is in and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Radius register write; only called while the block is idle.
  task automatic write_radius(logic [rnc_pkg::RADIUS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    radius_now  = value;
    radius_writes++;
  endtask

  // One set of points around a random centre, with occasional exact duplicates.
  task automatic send_cluster(int size);
    int unsigned                 spread;
    logic [rnc_pkg::COORD_W-1:0] bx;
    logic [rnc_pkg::COORD_W-1:0] by;
    logic [rnc_pkg::COORD_W-1:0] px;
    logic [rnc_pkg::COORD_W-1:0] py;
    case ($urandom_range(0, 4))
      0:       spread = 8;
      1:       spread = 60;
      2:       spread = 300;
      3:       spread = 3000;
      default: spread = 65535;
    endcase
    bx = rnc_pkg::COORD_W'($urandom_range(0, 65535 - spread));
    by = rnc_pkg::COORD_W'($urandom_range(0, 65535 - spread));
    px = bx;
    py = by;
    for (int i = 0; i < size; i++) begin
      if (i == 0 || $urandom_range(0, 9) != 0) begin
        px = rnc_pkg::COORD_W'(bx + $urandom_range(0, spread));
        py = rnc_pkg::COORD_W'(by + $urandom_range(0, spread));
      end
      send_point(px, py, i == size - 1);
    end
  endtask

  // A set of one point has no neighbours.
  task automatic test_single_point();
    send_point(16'd100, 16'd100, 1'b1);
    wait_idle();
  endtask

  // Exact duplicates lie at distance zero and are not counted.
  task automatic test_duplicates();
    send_point(16'd500, 16'd500, 1'b0);
    send_point(16'd500, 16'd500, 1'b0);
    send_point(16'd510, 16'd500, 1'b1);
    wait_idle();
  endtask

  // Squared distance equal to the radius is outside; one below is inside.
  task automatic test_radius_boundary();
    write_radius(rnc_pkg::RADIUS_RESET);
    send_point(16'd1000, 16'd1000, 1'b0);
    send_point(16'd1160, 16'd1000, 1'b0);
    send_point(16'd1159, 16'd1000, 1'b0);
    send_point(16'd1000, 16'd1160, 1'b1);
    wait_idle();
  endtask

  // Corner coordinates under the widest radius exercise the full-width sum.
  task automatic test_coordinate_extremes();
    write_radius(RADIUS_WIDEST);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'hFFFF, 1'b0);
    send_point(16'hFFFF, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFE, 1'b0);
    send_point(16'h0000, 16'h0001, 1'b1);
    wait_idle();
  endtask

  // A zero radius, and a radius of one, admit no neighbour at all.
  task automatic test_tiny_radius();
    write_radius(RADIUS_NONE);
    send_point(16'd20, 16'd20, 1'b0);
    send_point(16'd21, 16'd20, 1'b0);
    send_point(16'd20, 16'd20, 1'b1);
    wait_idle();
    write_radius(RADIUS_ONE);
    send_point(16'd20, 16'd20, 1'b0);
    send_point(16'd21, 16'd20, 1'b0);
    send_point(16'd20, 16'd20, 1'b1);
    wait_idle();
  endtask

  // More points than the set holds: the surplus is dropped, the final flag still counts.
  task automatic test_set_overflow();
    write_radius(rnc_pkg::RADIUS_RESET);
    quiet = 1'b1;
    send_cluster(rnc_pkg::MAX_POINTS + 6);
    quiet = 1'b0;
    wait_idle();
  endtask

  // The receiver holds off long while two sets are offered, so the input stalls.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    send_cluster(6);
    send_cluster(6);
    wait_idle();
  endtask

  // Random sets over a sequence of radius settings, extremes among them.
  task automatic test_random_sets();
    int unsigned start;
    int unsigned phase;
    int unsigned roll;
    int          size;
    start = points_sent;
    phase = 0;
    while (points_sent - start < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       write_radius(RADIUS_NONE);
        1:       write_radius(RADIUS_WIDEST);
        2:       write_radius($urandom_range(1, 200000));
        3:       write_radius($urandom());
        4:       write_radius(RADIUS_ONE);
        default: write_radius(rnc_pkg::RADIUS_RESET);
      endcase
      repeat ($urandom_range(2, 5)) begin
        roll = $urandom_range(0, 99);
        if (roll < 85)      size = $urandom_range(1, 10);
        else if (roll < 97) size = $urandom_range(11, 30);
        else                size = rnc_pkg::MAX_POINTS;
        quiet = ($urandom_range(0, 4) == 0);
        send_cluster(size);
      end
      quiet = 1'b0;
      wait_idle();
      phase++;
    end
  endtask

  // Receiver: checks each count transfer and drives ready with stalls and hold-offs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        counts_checked++;
        if (expected_counts.size() == 0) begin
          errors++;
          $display("%0t: unexpected count transfer, actual count %0d last %0b",
                   $time, out_data.neighbor_count, out_data.last_count);
        end else begin
          if (out_data.neighbor_count !== expected_counts[0].neighbor_count) begin
            errors++;
            $display("%0t: neighbor_count mismatch, expected %0d actual %0d", $time,
                     expected_counts[0].neighbor_count, out_data.neighbor_count);
          end
          if (out_data.last_count !== expected_counts[0].last_count) begin
            errors++;
            $display("%0t: last_count mismatch, expected %0b actual %0b", $time,
                     expected_counts[0].last_count, out_data.last_count);
          end
          void'(expected_counts.pop_front());
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d counts outstanding",
                 $time, idle_cycles, expected_counts.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_point();
    test_duplicates();
    test_radius_boundary();
    test_coordinate_extremes();
    test_tiny_radius();
    test_set_overflow();
    test_output_backpressure();
    test_random_sets();
    $display("Covered %0d points in %0d sets and %0d count transfers under %0d radius writes,",
             points_sent, sets_done, counts_checked, radius_writes);
    $display("including set overflow, duplicates, radius boundaries and a long output hold-off.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
